[rtl/odo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odo_pkg
// Shared constants and the arctangent table for the odometry integrator.
// ----------------------------------------------------------------------------
package odo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_COUNT   = 24;
   localparam int STEP_W       = $clog2(ATAN_COUNT);

   localparam logic [23:0] INV_WHEEL_BASE_RESET = 24'd327680;

   localparam logic signed [39:0] HALF_PI_Q30    = 40'sd1686629713;
   localparam logic signed [39:0] QUARTER_PI_Q30 = 40'sd843314856;
   localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;

   function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return $signed({2'b00, v});
   endfunction

endpackage
`default_nettype wire

[rtl/odo_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odo_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module odo_mul import odo_pkg::*; (
   input  wire logic               clock,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [63:0]      p
);

   logic signed [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

[rtl/odo_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odo_cordic
// Quadrant reduction by reciprocal estimate, then iterative CORDIC rotation.
// ----------------------------------------------------------------------------
module odo_cordic import odo_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [23:0] heading,
   output logic                    done,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);

   // floor(2^40 / half pi in Q.30); estimate is low by at most one
   localparam logic [9:0] RECIP_HALF_PI = 10'd651;

   typedef enum logic [2:0] {C_IDLE, C_EST, C_DIV, C_SETUP, C_ROT, C_FIX} cstate_type;

   cstate_type         state_ff;
   logic               neg_ff;
   logic [39:0]        rem_ff;
   logic [7:0]         q_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [1:0]         quad_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               done_ff;
   logic signed [31:0] cos_ff, sin_ff;

   logic signed [38:0] th_sum;
   logic [39:0]        div_in;
   logic [31:0]        q_prod;
   logic [39:0]        qh;
   logic signed [40:0] rem_sub;
   logic signed [40:0] trial;
   logic signed [33:0] xs, ys, at;
   logic signed [39:0] z_pos, z_neg;

   always_comb begin
      th_sum  = 39'(heading) * 39'sd16384 + 39'(QUARTER_PI_Q30);
      div_in  = th_sum[38] ? 40'(~th_sum) : 40'(th_sum);
      q_prod  = 32'(rem_ff[37:16]) * 32'(RECIP_HALF_PI);
      qh      = 40'(q_ff) * 40'(HALF_PI_Q30);
      rem_sub = $signed({1'b0, rem_ff}) - $signed({1'b0, qh});
      trial   = rem_sub - 41'(HALF_PI_Q30);
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = atan_q30(step_ff);
      z_pos   = $signed(rem_ff) - QUARTER_PI_Q30;
      z_neg   = HALF_PI_Q30 - 40'sd1 - QUARTER_PI_Q30 - $signed(rem_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  neg_ff   <= th_sum[38];
                  rem_ff   <= div_in;
                  state_ff <= C_EST;
               end
            end
            C_EST: begin
               q_ff     <= q_prod[31:24];
               state_ff <= C_DIV;
            end
            C_DIV: begin
               if (!trial[40]) begin
                  rem_ff <= trial[39:0];
                  q_ff   <= q_ff + 8'd1;
               end else begin
                  rem_ff <= rem_sub[39:0];
               end
               state_ff <= C_SETUP;
            end
            C_SETUP: begin
               z_ff     <= neg_ff ? z_neg[33:0] : z_pos[33:0];
               quad_ff  <= neg_ff ? ~q_ff[1:0] : q_ff[1:0];
               x_ff     <= CORDIC_GAIN;
               y_ff     <= '0;
               step_ff  <= '0;
               state_ff <= C_ROT;
            end
            C_ROT: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= C_FIX;
               end
            end
            C_FIX: begin
               unique case (quad_ff)
                  2'd0: begin cos_ff <= x_ff[31:0];    sin_ff <= y_ff[31:0];    end
                  2'd1: begin cos_ff <= -y_ff[31:0];   sin_ff <= x_ff[31:0];    end
                  2'd2: begin cos_ff <= -x_ff[31:0];   sin_ff <= -y_ff[31:0];   end
                  default: begin cos_ff <= y_ff[31:0]; sin_ff <= -x_ff[31:0];   end
               endcase
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == C_IDLE) else $error("cordic started while busy");
   a_done_fix: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(state_ff == C_FIX)) else $error("stray cordic done");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_ROT |-> step_ff < STEP_W'(CORDIC_STEPS)) else $error("step overrun");

endmodule
`default_nettype wire

[rtl/diff_drive_odometry_integrator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_top
// Dead-reckoning odometry for a two-wheel platform.
// ----------------------------------------------------------------------------
// Input beats on req_*: tuser=1 loads the stored heading and gives no result;
// tuser=0 carries wheel speeds and elapsed time and gives one result beat.
// csr_wr_en writes the reciprocal wheel base; write only while idle.
// A speed beat, once accepted, goes through three multiplier passes and
// the heading update, the CORDIC start, the CORDIC unit (reciprocal
// estimate, one correction step, setup, CORDIC_STEPS rotation steps,
// quadrant fix, hand-over), two multiplier passes, the y update and the
// output load. rsp_tvalid rises when the output register is loaded; no
// new beat is taken before then. A heading beat leaves the block idle.
// req_tready is low while a beat is in work. The result sits in an output
// register; a stalled receiver holds the block in its final state until
// the pending beat is taken. Reset clears position, heading and sets the
// wheel base to 5.0 1/m.
// ----------------------------------------------------------------------------
module diff_drive_odometry_integrator_top import odo_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [23:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // left_speed[15:0], right_speed[31:16], delta_time[47:32], heading_in[71:48]
   input  wire logic [71:0]  req_tdata,
   // func
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_out_x[31:0], pos_out_y[63:32], heading_out[87:64],
   // lin_speed_out[103:88], rot_speed_out[123:104], zero pad
   output logic [127:0]      rsp_tdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_M1, S_M2, S_M3, S_M4, S_TRIG, S_WAIT, S_MX, S_MY, S_PY, S_OUT
   } state_type;

   state_type          state_ff;
   logic [23:0]        inv_ff;
   logic signed [23:0] ref_heading_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic signed [15:0] lin_ff;
   logic signed [16:0] diff_ff;
   logic [15:0]        dt_ff;
   logic signed [19:0] rot_ff;
   logic signed [31:0] dist_ff;
   logic signed [23:0] heading_ff;
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic               cordic_done;
   logic signed [31:0] cos_v, sin_v;
   logic               req_fire;
   logic signed [16:0] lr_sum;
   logic signed [25:0] head_sum;
   logic signed [32:0] px_sum, py_sum;
   logic signed [31:0] out_x;

   function automatic logic signed [19:0] sat20(input logic signed [25:0] v);
      if (v > 26'sd524287)       return 20'sh7FFFF;
      else if (v < -26'sd524288) return 20'sh80000;
      else                       return v[19:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607)       return 24'sh7FFFFF;
      else if (v < -26'sd8388608) return 24'sh800000;
      else                        return v[23:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else                return v[31:0];
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign lr_sum     = 17'($signed(req_tdata[15:0])) + 17'($signed(req_tdata[31:16]));

   always_comb begin
      unique case (state_ff)
         S_M1: begin mul_a = $signed({8'b0, inv_ff}); mul_b = 32'(diff_ff); end
         S_M2: begin mul_a = 32'(lin_ff);  mul_b = $signed({16'b0, dt_ff}); end
         S_M3: begin mul_a = 32'(rot_ff);  mul_b = $signed({16'b0, dt_ff}); end
         S_MX: begin mul_a = dist_ff;      mul_b = cos_v; end
         S_MY: begin mul_a = dist_ff;      mul_b = sin_v; end
         default: begin mul_a = '0;        mul_b = '0; end
      endcase
   end

   odo_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   odo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_TRIG),
      .heading (heading_ff),
      .done    (cordic_done),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   assign head_sum = 26'(ref_heading_ff) + 26'($signed(prod[36:12]));
   assign px_sum   = 33'(pos_x_ff) + 33'($signed(prod[63:42]));
   assign py_sum   = 33'(pos_y_ff) + 33'($signed(prod[63:42]));
   assign out_x    = (pos_y_ff == 32'sh80000000) ? 32'sh7FFFFFFF : -pos_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         inv_ff         <= INV_WHEEL_BASE_RESET;
         ref_heading_ff <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            inv_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser) begin
                     ref_heading_ff <= $signed(req_tdata[71:48]);
                  end else begin
                     lin_ff   <= lr_sum[16:1];
                     diff_ff  <= 17'($signed(req_tdata[31:16]))
                                 - 17'($signed(req_tdata[15:0]));
                     dt_ff    <= req_tdata[47:32];
                     state_ff <= S_M1;
                  end
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: begin
               rot_ff   <= sat20($signed(prod[41:16]));
               state_ff <= S_M3;
            end
            S_M3: begin
               dist_ff  <= prod[31:0];
               state_ff <= S_M4;
            end
            S_M4: begin
               heading_ff <= sat24(head_sum);
               state_ff   <= S_TRIG;
            end
            S_TRIG: state_ff <= S_WAIT;
            S_WAIT: begin
               if (cordic_done) begin
                  state_ff <= S_MX;
               end
            end
            S_MX: state_ff <= S_MY;
            S_MY: begin
               pos_x_ff <= sat32(px_sum);
               state_ff <= S_PY;
            end
            S_PY: begin
               pos_y_ff <= sat32(py_sum);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {4'b0, rot_ff, lin_ff, heading_ff, pos_x_ff, out_x};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT)) else $error("result without work");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_WAIT) else $error("cordic result unexpected");
   a_corr_no_move: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> $stable(pos_x_ff) && $stable(pos_y_ff)
         && state_ff == S_IDLE) else $error("heading beat moved position");

endmodule
`default_nettype wire

[sim/tb_diff_drive_odometry_integrator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_integrator_top
// Self-checking bench for the odometry integrator: heading and speed beats,
// wheel base settings, random gaps on both sides, results checked per field.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_integrator_top;
   import odo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {FUNC_SPEED = 1'b0, FUNC_HEADING = 1'b1} func_type;

   typedef struct packed {
      func_type           func;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [15:0]        delta_time;
      logic signed [23:0] heading_in;
   } odo_req_type;

   typedef struct packed {
      logic signed [31:0] pos_out_x;
      logic signed [31:0] pos_out_y;
      logic signed [23:0] heading_out;
      logic signed [15:0] lin_speed_out;
      logic signed [19:0] rot_speed_out;
   } odo_rsp_type;

   localparam longint CYCLE_LIMIT = 1500000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [23:0]  csr_wr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;

   diff_drive_odometry_integrator_top u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [23:0]    wheel_base_inv;
   longint         heading_ref;
   longint         track_x;
   longint         track_y;

   odo_req_type    pending_beats[$];
   odo_rsp_type    expected_poses[$];
   int             error_count = 0;
   longint         cycle_count = 0;
   bit             feed_paused = 1'b0;

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint fdiv(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   task automatic heading_to_cos_sin(input longint hd, output longint c, output longint s);
      longint th, k, z, x, y, nx, at;
      th = hd * 16384;
      k = fdiv(th + QUARTER_PI_Q30, HALF_PI_Q30);
      z = th - k * HALF_PI_Q30;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_COUNT; i++) begin
         at = atan_q30(i[STEP_W-1:0]);
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - at;
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + at;
         end
         x = nx;
      end
      case (k & 3)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic integrate_beat(input odo_req_type b);
      longint l, r, dt, lin, rot, hd, travel, c, s;
      odo_rsp_type e;
      if (b.func == FUNC_HEADING) begin
         heading_ref = longint'(b.heading_in);
         return;
      end
      l = longint'(b.left_speed);
      r = longint'(b.right_speed);
      dt = longint'(b.delta_time);
      lin = (l + r) >>> 1;
      rot = clamp((longint'(wheel_base_inv) * (r - l)) >>> 16, 20);
      hd = clamp(heading_ref + ((rot * dt) >>> 12), 24);
      travel = lin * dt;
      heading_to_cos_sin(hd, c, s);
      track_x = clamp(track_x + ((travel * c) >>> 42), 32);
      track_y = clamp(track_y + ((travel * s) >>> 42), 32);
      e.pos_out_x = 32'(clamp(-track_y, 32));
      e.pos_out_y = 32'(track_x);
      e.heading_out = 24'(hd);
      e.lin_speed_out = 16'(lin);
      e.rot_speed_out = 20'(rot);
      expected_poses.push_back(e);
   endtask

   // driver
   int   send_gap = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            integrate_beat(pending_beats.pop_front());
            send_gap = $urandom_range(0, 12);
         end
         if ((!req_tvalid || req_tready) && !reset) begin
            if (feed_paused || pending_beats.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (send_gap > 0 && !(req_tvalid && !req_tready)) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_beats[0].func;
               req_tdata <= {pending_beats[0].heading_in, pending_beats[0].delta_time,
                             pending_beats[0].right_speed, pending_beats[0].left_speed};
            end
         end
      end
   end

   // monitor
   int   take_gap = 0;
   always @(posedge clock) begin
      odo_rsp_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.pos_out_x = rsp_tdata[31:0];
            got.pos_out_y = rsp_tdata[63:32];
            got.heading_out = rsp_tdata[87:64];
            got.lin_speed_out = rsp_tdata[103:88];
            got.rot_speed_out = rsp_tdata[123:104];
            if (expected_poses.size() == 0) begin
               $error("unexpected result beat");
               error_count++;
            end else begin
               want = expected_poses.pop_front();
               if (got.pos_out_x !== want.pos_out_x) begin
                  $error("pos_out_x exp %0d got %0d", want.pos_out_x, got.pos_out_x);
                  error_count++;
               end
               if (got.pos_out_y !== want.pos_out_y) begin
                  $error("pos_out_y exp %0d got %0d", want.pos_out_y, got.pos_out_y);
                  error_count++;
               end
               if (got.heading_out !== want.heading_out) begin
                  $error("heading_out exp %0d got %0d", want.heading_out, got.heading_out);
                  error_count++;
               end
               if (got.lin_speed_out !== want.lin_speed_out) begin
                  $error("lin_speed_out exp %0d got %0d",
                         want.lin_speed_out, got.lin_speed_out);
                  error_count++;
               end
               if (got.rot_speed_out !== want.rot_speed_out) begin
                  $error("rot_speed_out exp %0d got %0d",
                         want.rot_speed_out, got.rot_speed_out);
                  error_count++;
               end
            end
            take_gap = $urandom_range(0, 12);
         end
         if (take_gap > 0) begin
            take_gap = take_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic odo_req_type speed_beat(input int l, input int r, input int dt);
      odo_req_type b;
      b.func = FUNC_SPEED;
      b.left_speed = 16'(l);
      b.right_speed = 16'(r);
      b.delta_time = 16'(dt);
      b.heading_in = 24'($urandom);
      return b;
   endfunction

   function automatic odo_req_type heading_beat(input int h);
      odo_req_type b;
      b = speed_beat($urandom, $urandom, $urandom);
      b.func = FUNC_HEADING;
      b.heading_in = 24'(h);
      return b;
   endfunction

   function automatic odo_req_type random_beat();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return heading_beat($urandom);
      if (sel == 1) return heading_beat($signed($urandom_range(0, 1647099)) - 823550);
      if (sel < 5) return speed_beat($urandom, $urandom, $urandom);
      return speed_beat($signed($urandom_range(0, 8191)) - 4096,
                        $signed($urandom_range(0, 8191)) - 4096, $urandom_range(0, 1400));
   endfunction

   task automatic drain();
      wait (pending_beats.size() == 0 && !req_tvalid);
      wait (expected_poses.size() == 0);
      feed_paused = 1'b1;
      repeat (60) @(posedge clock);
   endtask

   task automatic write_wheel_base(input logic [23:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wheel_base_inv = v;
   endtask

   task automatic run_phase(input int n);
      for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
      feed_paused = 1'b0;
      drain();
   endtask

   initial begin
      wheel_base_inv = INV_WHEEL_BASE_RESET;
      heading_ref = 0;
      track_x = 0;
      track_y = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      feed_paused = 1'b1;

      // directed
      pending_beats.push_back(speed_beat(32767, 32767, 65535));
      pending_beats.push_back(speed_beat(-32768, -32768, 65535));
      pending_beats.push_back(speed_beat(-32768, 32767, 65535));
      pending_beats.push_back(speed_beat(32767, -32768, 65535));
      pending_beats.push_back(speed_beat(0, 0, 0));
      pending_beats.push_back(speed_beat(4096, 4096, 0));
      pending_beats.push_back(heading_beat(8388607));
      pending_beats.push_back(speed_beat(-1, -2, 1000));
      pending_beats.push_back(speed_beat(4096, 4096, 65535));
      pending_beats.push_back(heading_beat(-8388608));
      pending_beats.push_back(speed_beat(4096, 4096, 65535));
      pending_beats.push_back(heading_beat(102944));
      pending_beats.push_back(speed_beat(2048, 2048, 1000));
      pending_beats.push_back(heading_beat(205887));
      pending_beats.push_back(speed_beat(32767, 32767, 65535));
      pending_beats.push_back(heading_beat(-102944));
      pending_beats.push_back(speed_beat(-100, 100, 500));
      pending_beats.push_back(heading_beat(0));
      feed_paused = 1'b0;
      drain();
      // drive y well negative along a quarter-turn heading
      for (int i = 0; i < 40; i++) begin
         pending_beats.push_back(heading_beat(102944));
         pending_beats.push_back(speed_beat(-32768, -32768, 65535));
      end
      feed_paused = 1'b0;
      drain();

      write_wheel_base(24'hFFFFFF);
      run_phase(350);
      write_wheel_base(24'd0);
      run_phase(300);
      write_wheel_base(24'($urandom));
      run_phase(350);
      write_wheel_base(24'd65536);
      run_phase(400);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
